// ===== hdl/r4fft_pkg.sv =====
// shared types, constants and twiddle table function of the radix-4 fft
`default_nettype none
package r4fft_pkg;

  localparam int unsigned CfgIndexBits = 4;
  localparam int unsigned CfgDataBits  = 4;
  localparam int unsigned QueueDepth   = 2;
  localparam int unsigned LogSizeReset = 10;

  localparam logic [CfgIndexBits-1:0] RegLogSize = CfgIndexBits'(0);
  localparam logic [CfgIndexBits-1:0] RegInverse = CfgIndexBits'(1);

  localparam longint unsigned PiQ30  = 64'd3373259426;
  localparam longint unsigned OneQ30 = 64'd1 << 30;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_FETCH = 1'b1
  } op_kind_e;

  typedef struct packed {
    op_kind_e kind;
    logic     last;
  } op_ctrl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FETCH,
    ST_RD,
    ST_SUM,
    ST_MUL,
    ST_RND,
    ST_WR,
    ST_NEXT
  } st_e;

  // cosine and sine magnitudes of quarter-wave point r, packed as {cos, sin}
  function automatic logic [63:0] tw_entry(input int unsigned r, input int unsigned ldm,
                                           input int unsigned twb);
    longint unsigned quarter;
    longint unsigned rr;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned tc;
    longint unsigned ts;
    longint unsigned c;
    longint unsigned s;
    longint unsigned vc;
    longint unsigned vs;
    longint unsigned one;
    longint sc;
    longint ss;
    bit swap;
    quarter = 64'd1 << (ldm - 2);
    rr = 64'(r);
    swap = 1'b0;
    if (2 * rr > quarter) begin
      rr = quarter - rr;
      swap = 1'b1;
    end
    x = (PiQ30 * rr + (64'd1 << (ldm - 2))) >> (ldm - 1);
    x2 = (x * x) >> 30;
    tc = OneQ30;
    ts = x;
    sc = longint'(tc);
    ss = longint'(ts);
    for (int k = 0; k < 8; k++) begin
      tc = ((tc * x2) >> 30) / 64'((2 * k + 1) * (2 * k + 2));
      ts = ((ts * x2) >> 30) / 64'((2 * k + 2) * (2 * k + 3));
      if (k % 2 == 1) begin
        sc = sc + longint'(tc);
        ss = ss + longint'(ts);
      end else begin
        sc = sc - longint'(tc);
        ss = ss - longint'(ts);
      end
    end
    c = (sc < 0) ? 64'd0 : 64'(sc);
    s = (ss < 0) ? 64'd0 : 64'(ss);
    one = 64'd1 << (twb - 1);
    vc = ((swap ? s : c) + (64'd1 << (30 - twb))) >> (31 - twb);
    vs = ((swap ? c : s) + (64'd1 << (30 - twb))) >> (31 - twb);
    if (vc > one) vc = one;
    if (vs > one) vs = one;
    return {vc[31:0], vs[31:0]};
  endfunction

endpackage
`default_nettype wire

// ===== hdl/r4fft_queue.sv =====
// short word queue between front and back
`default_nettype none
module r4fft_queue import r4fft_pkg::*; #(
  parameter int unsigned WIDTH = 52
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire op_ctrl_t         ctrl_i,
  input  wire logic [WIDTH-1:0] data_i,
  input  wire logic             pop_i,
  output logic                  full_o,
  output logic                  empty_o,
  output op_ctrl_t              ctrl_o,
  output logic [WIDTH-1:0]      data_o
);

  localparam int unsigned PtrBits = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntBits = $clog2(QueueDepth + 1);

  op_ctrl_t                 ctrl_q [QueueDepth];
  logic [WIDTH-1:0]         data_q [QueueDepth];
  logic [PtrBits-1:0]       wr_ptr_q, rd_ptr_q;
  logic [CntBits-1:0]       cnt_q;

  assign full_o  = (cnt_q == CntBits'(QueueDepth));
  assign empty_o = (cnt_q == '0);
  assign ctrl_o  = ctrl_q[rd_ptr_q];
  assign data_o  = data_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrBits'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrBits'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ctrl_q[wr_ptr_q] <= ctrl_i;
      data_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/r4fft_front.sv =====
// front end: configuration, frame counters and word classification
`default_nettype none
module r4fft_front import r4fft_pkg::*; #(
  parameter int unsigned LM = 10,
  parameter int unsigned SB = 16,
  parameter int unsigned LW = 4,
  parameter int unsigned QW = 52
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_valid_i,
  output logic                         cfg_ready_o,
  input  wire logic [CfgIndexBits-1:0] cfg_index_i,
  input  wire logic [CfgDataBits-1:0]  cfg_data_i,
  input  wire logic                    in_valid_i,
  output logic                         in_stall_o,
  input  wire logic                    func_i,
  input  wire logic signed [SB-1:0]    sample_re_i,
  input  wire logic signed [SB-1:0]    sample_im_i,
  input  wire logic                    q_full_i,
  output logic                         q_push_o,
  output op_ctrl_t                     q_ctrl_o,
  output logic [QW-1:0]                q_data_o,
  output logic [LW-1:0]                log_size_o,
  output logic                         inverse_o
);

  logic [LW-1:0] log_size_q;
  logic          inverse_q;
  logic [LM:0]   load_count_q, read_count_q;
  logic          frame_ready_q;

  logic [LM:0]   n_pts, nm1, idx, idx_inc, k, k_inc;
  logic          load_last, fetch_last, acc, cfg_hit;
  logic [LM-1:0] rev, addr_f;
  op_kind_e      kind;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = q_full_i;
  assign log_size_o  = log_size_q;
  assign inverse_o   = inverse_q;

  always_comb begin
    n_pts      = (LM + 1)'(1) << log_size_q;
    nm1        = n_pts - 1'b1;
    idx        = load_count_q & nm1;
    idx_inc    = idx + 1'b1;
    load_last  = (idx_inc >= n_pts);
    k          = read_count_q & nm1;
    k_inc      = k + 1'b1;
    fetch_last = (k_inc >= n_pts);
    for (int b = 0; b < LM; b++) begin
      rev[b] = k[LM-1-b];
    end
    addr_f   = rev >> (LW'(LM) - log_size_q);
    kind     = op_kind_e'(func_i);
    acc      = in_valid_i && !q_full_i;
    cfg_hit  = cfg_valid_i && ((cfg_index_i == RegLogSize) || (cfg_index_i == RegInverse));
    q_push_o = acc && ((kind == OP_LOAD) || frame_ready_q);
    q_ctrl_o.kind = kind;
    if (kind == OP_LOAD) begin
      q_ctrl_o.last = load_last;
      q_data_o      = {LM'(idx), LM'(0), sample_re_i, sample_im_i};
    end else begin
      q_ctrl_o.last = fetch_last;
      q_data_o      = {addr_f, LM'(k), SB'(0), SB'(0)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      log_size_q    <= LW'((LogSizeReset > LM) ? LM : LogSizeReset);
      inverse_q     <= 1'b0;
      load_count_q  <= '0;
      read_count_q  <= '0;
      frame_ready_q <= 1'b0;
    end else if (cfg_hit) begin
      if (cfg_index_i == RegLogSize) begin
        log_size_q <= (int'(cfg_data_i) > int'(LM)) ? LW'(LM) : LW'(cfg_data_i);
      end else begin
        inverse_q <= cfg_data_i[0];
      end
      load_count_q  <= '0;
      read_count_q  <= '0;
      frame_ready_q <= 1'b0;
    end else if (acc) begin
      if (kind == OP_LOAD) begin
        if (load_last) begin
          load_count_q  <= '0;
          read_count_q  <= '0;
          frame_ready_q <= 1'b1;
        end else begin
          load_count_q <= idx_inc;
          if (frame_ready_q) begin
            frame_ready_q <= 1'b0;
            read_count_q  <= '0;
          end
        end
      end else if (frame_ready_q) begin
        if (fetch_last) begin
          read_count_q  <= '0;
          frame_ready_q <= 1'b0;
        end else begin
          read_count_q <= k_inc;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/r4fft_back.sv =====
// back end: work memory, butterfly sequencer and result register
`default_nettype none
module r4fft_back import r4fft_pkg::*; #(
  parameter int unsigned LM  = 10,
  parameter int unsigned SB  = 16,
  parameter int unsigned TW  = 16,
  parameter int unsigned LW  = 4,
  parameter int unsigned QW  = 52,
  parameter int unsigned ACC = 26
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic [LW-1:0]          log_size_i,
  input  wire logic                   inverse_i,
  input  wire logic                   q_empty_i,
  input  wire op_ctrl_t               q_ctrl_i,
  input  wire logic [QW-1:0]          q_data_i,
  output logic                        q_pop_o,
  output logic                        out_valid_o,
  input  wire logic                   out_stall_i,
  output logic signed [ACC-1:0]       result_re_o,
  output logic signed [ACC-1:0]       result_im_o,
  output logic [LM-1:0]               bin_index_o,
  output logic                        last_bin_o
);

  localparam int unsigned Depth = 2 ** LM;
  localparam int unsigned Qd    = 2 ** (LM - 2);
  localparam int unsigned QB    = (LM > 2) ? LM - 2 : 1;
  localparam int unsigned SW    = ACC + 2;
  localparam int unsigned PW    = ACC + TW + 4;
  localparam logic signed [PW-1:0] SatHi = {{(PW - ACC + 1){1'b0}}, {(ACC - 1){1'b1}}};
  localparam logic signed [PW-1:0] SatLo = ~SatHi;
  localparam logic signed [PW-1:0] Half  = PW'(1) << (TW - 2);

  function automatic logic signed [ACC-1:0] sat_acc(input logic signed [PW-1:0] v);
    logic signed [ACC-1:0] r;
    if (v > SatHi) begin
      r = SatHi[ACC-1:0];
    end else if (v < SatLo) begin
      r = SatLo[ACC-1:0];
    end else begin
      r = v[ACC-1:0];
    end
    return r;
  endfunction

  // quarter-wave twiddle table
  logic [2*TW-1:0] rom [Qd];
  for (genvar g = 0; g < Qd; g++) begin : g_rom
    localparam logic [63:0] Ent = tw_entry(g, LM, TW);
    assign rom[g] = {Ent[32 +: TW], Ent[0 +: TW]};
  end

  logic [2*ACC-1:0] mem_q [Depth];
  logic [2*ACC-1:0] rdata_q;
  logic             mem_we, mem_re;
  logic [LM-1:0]    mem_wa, mem_ra;
  logic [2*ACC-1:0] mem_wd;

  st_e           st_q, st_d;
  logic [2:0]    cnt_q;
  logic [1:0]    kk_q;
  logic [LW-1:0] ldm_q;
  logic [LM-1:0] j_q;
  logic [LM:0]   base_q;
  logic          r2_q;
  logic          out_valid_q;
  logic [LM-1:0] fetch_k_q;
  logic          fetch_last_q;

  logic signed [ACC-1:0] x_re_q [4], x_im_q [4];
  logic signed [ACC-1:0] z_re_q [4], z_im_q [4];
  logic signed [SW-1:0]  y_re_q [3], y_im_q [3];
  logic signed [TW:0]    w_re_q [3], w_im_q [3];
  logic signed [PW-1:0]  p_rr_q, p_ii_q, p_ri_q, p_ir_q;
  logic signed [ACC-1:0] res_re_q, res_im_q;
  logic [LM-1:0]         res_bin_q;
  logic                  res_last_q;

  logic [LM:0]   n_pts, m4, m_sel, stride, i0, off;
  logic [LM-1:0] addr_pt;
  logic [2:0]    np;
  logic          last_base, last_j, out_free;
  logic [LM-1:0] q_addr;
  logic signed [SB-1:0] q_re, q_im;

  logic signed [SW-1:0] xe_re [4], xe_im [4];
  logic signed [SW-1:0] sr, si, dr, di, pr, pim, qr, qi, jr, ji;
  logic [LM-1:0]        u [3];
  logic [QB-1:0]        ri [3];
  logic [1:0]           qd [3];
  logic signed [TW:0]   tc [3], ts [3], cr [3], ci [3];
  logic signed [PW-1:0] s_re, s_im;

  assign q_addr = q_data_i[QW-1 -: LM];
  assign q_re   = q_data_i[2*SB-1:SB];
  assign q_im   = q_data_i[SB-1:0];

  assign out_valid_o = out_valid_q;
  assign result_re_o = res_re_q;
  assign result_im_o = res_im_q;
  assign bin_index_o = res_bin_q;
  assign last_bin_o  = res_last_q;

  // addressing
  always_comb begin
    n_pts     = (LM + 1)'(1) << log_size_i;
    m4        = (LM + 1)'(1) << (ldm_q - LW'(2));
    m_sel     = r2_q ? (LM + 1)'(2) : ((LM + 1)'(1) << ldm_q);
    stride    = r2_q ? (LM + 1)'(1) : m4;
    i0        = (LM + 1)'(j_q) + base_q;
    off       = (cnt_q[1] ? (stride << 1) : '0) + (cnt_q[0] ? stride : '0);
    addr_pt   = LM'(i0 + off);
    np        = r2_q ? 3'd2 : 3'd4;
    last_base = ((base_q + m_sel) >= n_pts);
    last_j    = (((LM + 1)'(j_q) + 1'b1) >= m4);
    out_free  = !out_valid_q || !out_stall_i;
  end

  // butterfly sums and twiddles
  always_comb begin
    for (int p = 0; p < 4; p++) begin
      xe_re[p] = SW'(x_re_q[p]);
      xe_im[p] = SW'(x_im_q[p]);
    end
    sr  = xe_re[0] + xe_re[2];
    si  = xe_im[0] + xe_im[2];
    dr  = xe_re[0] - xe_re[2];
    di  = xe_im[0] - xe_im[2];
    pr  = xe_re[1] + xe_re[3];
    pim = xe_im[1] + xe_im[3];
    qr  = xe_re[1] - xe_re[3];
    qi  = xe_im[1] - xe_im[3];
    jr  = inverse_i ? -qi : qi;
    ji  = inverse_i ? qr : -qr;
    u[1] = LM'(j_q << (LW'(LM) - ldm_q));
    u[0] = u[1] << 1;
    u[2] = u[1] + u[0];
    for (int l = 0; l < 3; l++) begin
      qd[l] = u[l][LM-1 -: 2];
      ri[l] = (LM > 2) ? QB'(u[l]) : '0;
      tc[l] = $signed({1'b0, rom[ri[l]][2*TW-1:TW]});
      ts[l] = $signed({1'b0, rom[ri[l]][TW-1:0]});
      case (qd[l])
        2'd0: begin
          cr[l] = tc[l];
          ci[l] = ts[l];
        end
        2'd1: begin
          cr[l] = -ts[l];
          ci[l] = tc[l];
        end
        2'd2: begin
          cr[l] = -tc[l];
          ci[l] = -ts[l];
        end
        default: begin
          cr[l] = ts[l];
          ci[l] = -tc[l];
        end
      endcase
    end
    s_re = p_rr_q - p_ii_q + Half;
    s_im = p_ri_q + p_ir_q + Half;
  end

  // sequencer next state and memory control
  always_comb begin
    st_d    = st_q;
    q_pop_o = 1'b0;
    mem_we  = 1'b0;
    mem_re  = 1'b0;
    mem_wa  = addr_pt;
    mem_ra  = addr_pt;
    mem_wd  = {z_re_q[cnt_q[1:0]], z_im_q[cnt_q[1:0]]};
    unique case (st_q)
      ST_IDLE: begin
        if (!q_empty_i) begin
          q_pop_o = 1'b1;
          if (q_ctrl_i.kind == OP_LOAD) begin
            mem_we = 1'b1;
            mem_wa = q_addr;
            mem_wd = {ACC'(q_re), ACC'(q_im)};
            if (q_ctrl_i.last && (log_size_i != '0)) begin
              st_d = ST_RD;
            end
          end else begin
            mem_re = 1'b1;
            mem_ra = q_addr;
            st_d   = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        if (out_free) begin
          st_d = ST_IDLE;
        end
      end
      ST_RD: begin
        if (cnt_q < np) begin
          mem_re = 1'b1;
        end else begin
          st_d = ST_SUM;
        end
      end
      ST_SUM: begin
        st_d = r2_q ? ST_WR : ST_MUL;
      end
      ST_MUL: begin
        st_d = ST_RND;
      end
      ST_RND: begin
        st_d = (kk_q == 2'd2) ? ST_WR : ST_MUL;
      end
      ST_WR: begin
        mem_we = 1'b1;
        if (cnt_q == np - 3'd1) begin
          st_d = ST_NEXT;
        end
      end
      ST_NEXT: begin
        if (!last_base) begin
          st_d = ST_RD;
        end else if (r2_q) begin
          st_d = ST_IDLE;
        end else if (!last_j) begin
          st_d = ST_RD;
        end else if (ldm_q >= LW'(4)) begin
          st_d = ST_RD;
        end else if (log_size_i[0]) begin
          st_d = ST_RD;
        end else begin
          st_d = ST_IDLE;
        end
      end
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      kk_q        <= '0;
      ldm_q       <= '0;
      j_q         <= '0;
      base_q      <= '0;
      r2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if ((st_q == ST_FETCH) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (st_q)
        ST_IDLE: begin
          if (!q_empty_i && (q_ctrl_i.kind == OP_LOAD) && q_ctrl_i.last) begin
            ldm_q  <= log_size_i;
            j_q    <= '0;
            base_q <= '0;
            cnt_q  <= '0;
            r2_q   <= (log_size_i < LW'(2));
          end
        end
        ST_FETCH: begin
        end
        ST_RD: begin
          cnt_q <= (cnt_q == np) ? '0 : cnt_q + 3'd1;
        end
        ST_SUM: begin
          kk_q  <= '0;
          cnt_q <= '0;
        end
        ST_MUL: begin
          kk_q <= kk_q;
        end
        ST_RND: begin
          kk_q <= kk_q + 2'd1;
        end
        ST_WR: begin
          cnt_q <= (cnt_q == np - 3'd1) ? '0 : cnt_q + 3'd1;
        end
        ST_NEXT: begin
          if (!last_base) begin
            base_q <= base_q + m_sel;
          end else begin
            base_q <= '0;
            if (!r2_q) begin
              if (!last_j) begin
                j_q <= j_q + 1'b1;
              end else begin
                j_q   <= '0;
                ldm_q <= ldm_q - LW'(2);
                if (ldm_q < LW'(4)) begin
                  r2_q <= 1'b1;
                end
              end
            end
          end
        end
        default: cnt_q <= '0;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (st_q)
      ST_IDLE: begin
        fetch_k_q    <= q_data_i[QW-LM-1 -: LM];
        fetch_last_q <= q_ctrl_i.last;
      end
      ST_FETCH: begin
        if (out_free) begin
          res_re_q   <= rdata_q[2*ACC-1:ACC];
          res_im_q   <= rdata_q[ACC-1:0];
          res_bin_q  <= fetch_k_q;
          res_last_q <= fetch_last_q;
        end
      end
      ST_RD: begin
        if (cnt_q != '0) begin
          x_re_q[2'(cnt_q - 3'd1)] <= rdata_q[2*ACC-1:ACC];
          x_im_q[2'(cnt_q - 3'd1)] <= rdata_q[ACC-1:0];
        end
      end
      ST_SUM: begin
        if (r2_q) begin
          z_re_q[0] <= sat_acc(PW'(xe_re[0] + xe_re[1]));
          z_im_q[0] <= sat_acc(PW'(xe_im[0] + xe_im[1]));
          z_re_q[1] <= sat_acc(PW'(xe_re[0] - xe_re[1]));
          z_im_q[1] <= sat_acc(PW'(xe_im[0] - xe_im[1]));
        end else begin
          z_re_q[0] <= sat_acc(PW'(sr + pr));
          z_im_q[0] <= sat_acc(PW'(si + pim));
        end
        y_re_q[0] <= sr - pr;
        y_im_q[0] <= si - pim;
        y_re_q[1] <= dr + jr;
        y_im_q[1] <= di + ji;
        y_re_q[2] <= dr - jr;
        y_im_q[2] <= di - ji;
        for (int l = 0; l < 3; l++) begin
          w_re_q[l] <= cr[l];
          w_im_q[l] <= inverse_i ? ci[l] : -ci[l];
        end
      end
      ST_MUL: begin
        p_rr_q <= PW'(y_re_q[kk_q]) * PW'(w_re_q[kk_q]);
        p_ii_q <= PW'(y_im_q[kk_q]) * PW'(w_im_q[kk_q]);
        p_ri_q <= PW'(y_re_q[kk_q]) * PW'(w_im_q[kk_q]);
        p_ir_q <= PW'(y_im_q[kk_q]) * PW'(w_re_q[kk_q]);
      end
      ST_RND: begin
        z_re_q[kk_q + 2'd1] <= sat_acc(s_re >>> (TW - 1));
        z_im_q[kk_q + 2'd1] <= sat_acc(s_im >>> (TW - 1));
      end
      default: begin
        res_last_q <= res_last_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      rdata_q <= mem_q[mem_ra];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/radix4_dif_fft.sv =====
// top level of the radix-4 decimation-in-frequency fft
`default_nettype none
// Streaming fixed-point FFT of 2^log_size points (log_size up to LOG_MAX_POINTS), no scaling.
// Load words (func 0) write samples in natural order; the load that completes the frame
// starts the in-place radix-4 passes, plus one radix-2 pass when log_size is odd. Fetch words
// (func 1) then return bins in natural order with bin_index and last_bin; a fetch with no
// finished frame is dropped, and a load while bins are pending starts a new frame. A config
// write restarts the frame. Words pass through a two-entry queue into a sequencer that shares
// one work memory, one access at a time. After the last load the sequencer runs each radix-4
// butterfly as four reads, three twiddle products (each a multiply step and a rounding step)
// and four writes, and the radix-2 pass as two reads, one sum and two writes per point pair;
// in_stall_o rises once the queue fills.
module radix4_dif_fft import r4fft_pkg::*; #(
  parameter int unsigned LOG_MAX_POINTS = 10,
  parameter int unsigned SAMPLE_BITS    = 16,
  parameter int unsigned TWIDDLE_BITS   = 16
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   cfg_valid_i,
  output logic                                        cfg_ready_o,
  input  wire logic [CfgIndexBits-1:0]                cfg_index_i,
  input  wire logic [CfgDataBits-1:0]                 cfg_data_i,
  input  wire logic                                   in_valid_i,
  output logic                                        in_stall_o,
  input  wire logic                                   func_i,
  input  wire logic signed [SAMPLE_BITS-1:0]          sample_re_i,
  input  wire logic signed [SAMPLE_BITS-1:0]          sample_im_i,
  output logic                                        out_valid_o,
  input  wire logic                                   out_stall_i,
  output logic signed [SAMPLE_BITS+LOG_MAX_POINTS-1:0] result_re_o,
  output logic signed [SAMPLE_BITS+LOG_MAX_POINTS-1:0] result_im_o,
  output logic [LOG_MAX_POINTS-1:0]                   bin_index_o,
  output logic                                        last_bin_o
);

  localparam int unsigned LW  = $clog2(LOG_MAX_POINTS + 1);
  localparam int unsigned QW  = 2 * LOG_MAX_POINTS + 2 * SAMPLE_BITS;
  localparam int unsigned ACC = SAMPLE_BITS + LOG_MAX_POINTS;

  logic          q_push, q_pop, q_full, q_empty;
  op_ctrl_t      f_ctrl, b_ctrl;
  logic [QW-1:0] f_data, b_data;
  logic [LW-1:0] log_size;
  logic          inverse;

  r4fft_front #(
    .LM(LOG_MAX_POINTS),
    .SB(SAMPLE_BITS),
    .LW(LW),
    .QW(QW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .sample_re_i (sample_re_i),
    .sample_im_i (sample_im_i),
    .q_full_i    (q_full),
    .q_push_o    (q_push),
    .q_ctrl_o    (f_ctrl),
    .q_data_o    (f_data),
    .log_size_o  (log_size),
    .inverse_o   (inverse)
  );

  r4fft_queue #(
    .WIDTH(QW)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .ctrl_i  (f_ctrl),
    .data_i  (f_data),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .empty_o (q_empty),
    .ctrl_o  (b_ctrl),
    .data_o  (b_data)
  );

  r4fft_back #(
    .LM(LOG_MAX_POINTS),
    .SB(SAMPLE_BITS),
    .TW(TWIDDLE_BITS),
    .LW(LW),
    .QW(QW),
    .ACC(ACC)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .log_size_i  (log_size),
    .inverse_i   (inverse),
    .q_empty_i   (q_empty),
    .q_ctrl_i    (b_ctrl),
    .q_data_i    (b_data),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_re_o (result_re_o),
    .result_im_o (result_im_o),
    .bin_index_o (bin_index_o),
    .last_bin_o  (last_bin_o)
  );

endmodule
`default_nettype wire

// ===== sim/fft_bin_checker.sv =====
// checker of the radix-4 fft: watches the channels, predicts the bins and compares them
`timescale 1ns / 1ps
module fft_bin_checker import r4fft_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  input  logic                    cfg_ready_i,
  input  logic [CfgIndexBits-1:0] cfg_index_i,
  input  logic [CfgDataBits-1:0]  cfg_data_i,
  input  logic                    in_valid_i,
  input  logic                    in_stall_i,
  input  logic                    func_i,
  input  logic signed [15:0]      sample_re_i,
  input  logic signed [15:0]      sample_im_i,
  input  logic                    out_valid_i,
  input  logic                    out_stall_i,
  input  logic signed [25:0]      result_re_i,
  input  logic signed [25:0]      result_im_i,
  input  logic [9:0]              bin_index_i,
  input  logic                    last_bin_i,
  output int                      pending_o,
  output int                      errors_o
);

  localparam int AccBits = 26;
  localparam longint AccMax = (64'sd1 <<< (AccBits - 1)) - 1;
  localparam longint AccMin = -AccMax - 1;

  typedef struct packed {
    logic signed [25:0] re;
    logic signed [25:0] im;
    logic [9:0]         bin;
    logic               last;
  } bin_t;

  bin_t   bins_due[$];
  longint mem_re[1024];
  longint mem_im[1024];
  int     load_cnt;
  int     read_cnt;
  bit     frame_done;
  int     log_n;
  bit     inv;
  int     errors;

  assign errors_o  = errors;

  function automatic longint clamp(input longint v);
    return v > AccMax ? AccMax : (v < AccMin ? AccMin : v);
  endfunction

  function automatic longint unsigned q15(input longint unsigned v);
    longint unsigned r;
    r = (v + (64'd1 << 14)) >> 15;
    return r > 64'd32768 ? 64'd32768 : r;
  endfunction

  // exp(+-2 pi i t / 2^ldm) in q15, one-octant taylor series in q2.30
  task automatic rotation(input int ldm, input int t, output longint wr, output longint wi);
    longint unsigned quarter, r, x, x2, tc, ts, c, s, vc, vs;
    longint sc, ss, cr, ci;
    int q;
    bit swap;
    quarter = 64'd1 << (ldm - 2);
    t = t & ((1 << ldm) - 1);
    q = t >> (ldm - 2);
    r = longint'(t) & (quarter - 1);
    swap = 0;
    if (2 * r > quarter) begin
      r = quarter - r;
      swap = 1;
    end
    x = (PiQ30 * r + (64'd1 << (ldm - 2))) >> (ldm - 1);
    x2 = (x * x) >> 30;
    tc = 64'd1 << 30;
    ts = x;
    sc = longint'(tc);
    ss = longint'(ts);
    for (int k = 0; k < 8; k++) begin
      tc = ((tc * x2) >> 30) / longint'((2 * k + 1) * (2 * k + 2));
      ts = ((ts * x2) >> 30) / longint'((2 * k + 2) * (2 * k + 3));
      if (k % 2 == 1) begin
        sc += longint'(tc);
        ss += longint'(ts);
      end else begin
        sc -= longint'(tc);
        ss -= longint'(ts);
      end
    end
    c = sc < 0 ? 0 : longint'(sc);
    s = ss < 0 ? 0 : longint'(ss);
    vc = q15(swap ? s : c);
    vs = q15(swap ? c : s);
    case (q)
      0: begin cr = vc;  ci = vs;  end
      1: begin cr = -vs; ci = vc;  end
      2: begin cr = -vc; ci = -vs; end
      default: begin cr = vs; ci = -vc; end
    endcase
    wr = cr;
    wi = inv ? ci : -ci;
  endtask

  task automatic rotate_into(input int idx, input longint ar, input longint ai,
                             input longint wr, input longint wi);
    mem_re[idx] = clamp((ar * wr - ai * wi + 64'sd16384) >>> 15);
    mem_im[idx] = clamp((ar * wi + ai * wr + 64'sd16384) >>> 15);
  endtask

  task automatic run_passes();
    int n, m, m4, i0, i1, i2, i3;
    longint e1r, e1i, e2r, e2i, e3r, e3i;
    longint sr, si, dr, di, pr, pi, qr, qi, jr, ji, ar, ai, br, bi;
    n = 1 << log_n;
    for (int ldm = log_n; ldm >= 2; ldm -= 2) begin
      m = 1 << ldm;
      m4 = m >> 2;
      for (int j = 0; j < m4; j++) begin
        rotation(ldm, j, e1r, e1i);
        rotation(ldm, 2 * j, e2r, e2i);
        rotation(ldm, 3 * j, e3r, e3i);
        for (int b = 0; b < n; b += m) begin
          i0 = j + b; i1 = i0 + m4; i2 = i1 + m4; i3 = i2 + m4;
          sr = mem_re[i0] + mem_re[i2]; si = mem_im[i0] + mem_im[i2];
          dr = mem_re[i0] - mem_re[i2]; di = mem_im[i0] - mem_im[i2];
          pr = mem_re[i1] + mem_re[i3]; pi = mem_im[i1] + mem_im[i3];
          qr = mem_re[i1] - mem_re[i3]; qi = mem_im[i1] - mem_im[i3];
          jr = inv ? -qi : qi;
          ji = inv ? qr : -qr;
          mem_re[i0] = clamp(sr + pr);
          mem_im[i0] = clamp(si + pi);
          rotate_into(i1, sr - pr, si - pi, e2r, e2i);
          rotate_into(i2, dr + jr, di + ji, e1r, e1i);
          rotate_into(i3, dr - jr, di - ji, e3r, e3i);
        end
      end
    end
    if (log_n % 2 == 1) begin
      for (int k = 0; k + 1 < n; k += 2) begin
        ar = mem_re[k]; ai = mem_im[k]; br = mem_re[k + 1]; bi = mem_im[k + 1];
        mem_re[k] = clamp(ar + br); mem_im[k] = clamp(ai + bi);
        mem_re[k + 1] = clamp(ar - br); mem_im[k + 1] = clamp(ai - bi);
      end
    end
  endtask

  task automatic apply_reg_write(input logic [CfgIndexBits-1:0] idx,
                                 input logic [CfgDataBits-1:0] val);
    if (idx == RegLogSize) begin
      log_n = val > 10 ? 10 : int'(val);
    end else if (idx == RegInverse) begin
      inv = val[0];
    end else begin
      return;
    end
    load_cnt = 0;
    read_cnt = 0;
    frame_done = 0;
  endtask

  task automatic accept_word(input logic f, input logic signed [15:0] re,
                             input logic signed [15:0] im);
    int n, idx, k, addr;
    bin_t b;
    n = 1 << log_n;
    if (op_kind_e'(f) == OP_LOAD) begin
      idx = load_cnt & (n - 1);
      if (frame_done) begin
        frame_done = 0;
        read_cnt = 0;
      end
      mem_re[idx] = re;
      mem_im[idx] = im;
      load_cnt = idx + 1;
      if (load_cnt >= n) begin
        run_passes();
        load_cnt = 0;
        read_cnt = 0;
        frame_done = 1;
      end
    end else if (frame_done) begin
      k = read_cnt & (n - 1);
      addr = 0;
      for (int i = 0; i < log_n; i++) addr |= ((k >> i) & 1) << (log_n - 1 - i);
      b.re = mem_re[addr][25:0];
      b.im = mem_im[addr][25:0];
      b.bin = k[9:0];
      b.last = (k == n - 1);
      bins_due.push_back(b);
      read_cnt = k + 1;
      if (read_cnt >= n) begin
        read_cnt = 0;
        frame_done = 0;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    bin_t e;
    if (!rst_ni) begin
      bins_due.delete();
      load_cnt = 0;
      read_cnt = 0;
      frame_done = 0;
      log_n = LogSizeReset;
      inv = 0;
      errors = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (bins_due.size() == 0) begin
          if (errors < 10) $display("unexpected bin %0d: re %0d im %0d", bin_index_i,
                                    result_re_i, result_im_i);
          errors = errors + 1;
        end else begin
          e = bins_due.pop_front();
          if (e.re !== result_re_i || e.im !== result_im_i || e.bin !== bin_index_i ||
              e.last !== last_bin_i) begin
            if (errors < 10)
              $display("bin mismatch: exp re %0d im %0d bin %0d last %0d, got %0d %0d %0d %0d",
                       e.re, e.im, e.bin, e.last, result_re_i, result_im_i, bin_index_i,
                       last_bin_i);
            errors = errors + 1;
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) apply_reg_write(cfg_index_i, cfg_data_i);
      if (in_valid_i && !in_stall_i) accept_word(func_i, sample_re_i, sample_im_i);
    end
    pending_o = bins_due.size();
  end

endmodule

// ===== sim/tb_radix4_dif_fft.sv =====
// stimulus and verdict for the radix-4 fft, with the bin checker beside the block
`timescale 1ns / 1ps
module tb_radix4_dif_fft;
  import r4fft_pkg::*;

  localparam int CycleLimit = 1000000;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [CfgIndexBits-1:0] cfg_index = '0;
  logic [CfgDataBits-1:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_stall;
  logic func = 0;
  logic signed [15:0] sample_re = '0;
  logic signed [15:0] sample_im = '0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [25:0] result_re;
  logic signed [25:0] result_im;
  logic [9:0] bin_index;
  logic last_bin;
  int pending;
  int errors;
  int words;
  int cycles;
  bit calm;
  int log_now;

  always begin
    #1 clk_i = 1;
    #1 clk_i = 0;
  end

  radix4_dif_fft u_top (
    .clk_i, .rst_ni,
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready), .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .func_i(func),
    .sample_re_i(sample_re), .sample_im_i(sample_im),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .result_re_o(result_re), .result_im_o(result_im), .bin_index_o(bin_index),
    .last_bin_o(last_bin)
  );

  fft_bin_checker u_check (
    .clk_i, .rst_ni,
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready), .cfg_index_i(cfg_index),
    .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_i(in_stall), .func_i(func),
    .sample_re_i(sample_re), .sample_im_i(sample_im),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .result_re_i(result_re), .result_im_i(result_im), .bin_index_i(bin_index),
    .last_bin_i(last_bin),
    .pending_o(pending), .errors_o(errors)
  );

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_stall <= 0;
    else out_stall <= !calm && $urandom_range(99) < 22;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // valid stays high after a word is taken until the next call decides
  task automatic send_word(input op_kind_e f, input logic [15:0] re, input logic [15:0] im);
    while (!calm && $urandom_range(99) < 22) begin
      in_valid <= 0;
      @(posedge clk_i);
    end
    in_valid <= 1;
    func <= f;
    sample_re <= re;
    sample_im <= im;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    words++;
  endtask

  function automatic logic [15:0] pick_sample(input int extreme_pct);
    if ($urandom_range(99) < extreme_pct) return $urandom_range(1) ? 16'h7fff : 16'h8000;
    return 16'($urandom);
  endfunction

  // wait until no bin is due and the block has finished every word and pass
  task automatic wait_idle();
    in_valid <= 0;
    @(posedge clk_i);
    while (pending != 0 || u_top.u_back.st_q != ST_IDLE || !u_top.q_empty)
      @(posedge clk_i);
    repeat (40) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIndexBits-1:0] idx, input logic [CfgDataBits-1:0] v);
    wait_idle();
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    cfg_valid <= 0;
    if (idx == RegLogSize) log_now = v > 10 ? 10 : v;
  endtask

  task automatic load_frame(input int count, input int extreme_pct);
    for (int i = 0; i < count; i++)
      send_word(OP_LOAD, pick_sample(extreme_pct), pick_sample(extreme_pct));
  endtask

  task automatic fetch_bins(input int count);
    for (int i = 0; i < count; i++) send_word(OP_FETCH, 16'($urandom), 16'($urandom));
  endtask

  initial begin
    int n, ph, pct;
    calm = 0;
    words = 0;
    log_now = LogSizeReset;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // fetch with no finished frame is dropped
    fetch_bins(1);
    // one-point frame
    write_reg(RegLogSize, 4'd0);
    send_word(OP_LOAD, 16'h8000, 16'h7fff);
    fetch_bins(2);
    // four points, positive sign, load while bins pending
    write_reg(RegLogSize, 4'd2);
    write_reg(RegInverse, 4'd1);
    send_word(OP_LOAD, 16'h7fff, 16'h8000);
    send_word(OP_LOAD, 16'h8000, 16'h8000);
    send_word(OP_LOAD, 16'h7fff, 16'h7fff);
    send_word(OP_LOAD, 16'h0000, 16'hffff);
    fetch_bins(2);
    load_frame(4, 50);
    fetch_bins(4);
    // two points, then a frame cut short by a register write
    write_reg(RegLogSize, 4'd1);
    load_frame(2, 100);
    fetch_bins(2);
    write_reg(RegLogSize, 4'd3);
    load_frame(3, 0);
    write_reg(RegInverse, 4'd0);
    load_frame(8, 30);
    fetch_bins(8);

    ph = 0;
    while (words < 1650) begin
      calm = (ph == 3);
      if (ph == 2) write_reg(RegLogSize, 4'd15);
      else if ($urandom_range(9) == 0) write_reg(RegLogSize, 4'($urandom_range(7, 9)));
      else write_reg(RegLogSize, 4'($urandom_range(0, 6)));
      write_reg(RegInverse, 4'($urandom));
      n = 1 << log_now;
      pct = (ph == 2) ? 60 : 10;
      for (int f = 0; f < (n >= 128 ? 0 : $urandom_range(2, 5)); f++) begin
        if ($urandom_range(9) == 0) begin
          for (int i = 0; i < $urandom_range(1, 6); i++)
            if ($urandom_range(1)) fetch_bins(1);
            else load_frame(1, pct);
        end
        load_frame(n, pct);
        if ($urandom_range(7) == 0 && n > 1) fetch_bins($urandom_range(1, n - 1));
        else fetch_bins(n);
      end
      load_frame(n, pct);
      fetch_bins(n >= 1024 ? 64 : n);
      ph++;
    end
    calm = 0;
    wait_idle();
    repeat (200) @(posedge clk_i);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== radix4_dif_fft.f =====
hdl/r4fft_pkg.sv
hdl/r4fft_queue.sv
hdl/r4fft_front.sv
hdl/r4fft_back.sv
hdl/radix4_dif_fft.sv
sim/fft_bin_checker.sv
sim/tb_radix4_dif_fft.sv
